FILE: design/rme_pkg.sv
package rme_pkg;
    localparam int FRAC_BITS = 14;
    localparam int ITERS = 16;
    localparam int ZW = 26;
    localparam int XW = 44;
    localparam int SCALE_SH = 24;
    localparam logic signed [ZW-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [ZW-1:0] ANGLE_LIMIT = 26'sd23040;
    localparam int RADW = 2 * FRAC_BITS + 4;
    localparam int CW = FRAC_BITS + 2;

    typedef logic signed [ZW-1:0] zang_t;
    typedef logic signed [XW-1:0] xval_t;

    function automatic zang_t atan_tab(input int i);
        zang_t v;
        case (i)
            0: v = 26'sd2949120;
            1: v = 26'sd1740967;
            2: v = 26'sd919879;
            3: v = 26'sd466945;
            4: v = 26'sd234379;
            5: v = 26'sd117304;
            6: v = 26'sd58666;
            7: v = 26'sd29335;
            8: v = 26'sd14668;
            9: v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

FILE: design/rme_cordic.sv
module rme_cordic (
    input  logic clk,
    input  logic advance,
    input  logic signed [18:0] y_in,
    input  logic signed [18:0] x_in,
    output logic signed [15:0] angle
);
    import rme_pkg::*;

    xval_t x_reg [ITERS+1];
    xval_t y_reg [ITERS+1];
    zang_t z_reg [ITERS+1];
    logic zero_reg [ITERS+1];
    logic signed [15:0] angle_reg;
    xval_t x0, y0;
    zang_t z0, zr;

    always_comb
    begin
        x0 = {{(XW-19-SCALE_SH){x_in[18]}}, x_in, {SCALE_SH{1'b0}}};
        y0 = {{(XW-19-SCALE_SH){y_in[18]}}, y_in, {SCALE_SH{1'b0}}};
        z0 = '0;
        if (x_in < 0)
        begin
            z0 = (y_in >= 0) ? DEG180 : -DEG180;
            x0 = -x0;
            y0 = -y0;
        end
        zr = (z_reg[ITERS] + zang_t'(256)) >>> 9;
        if (zr > ANGLE_LIMIT)
        begin
            zr = ANGLE_LIMIT;
        end
        if (zr < -ANGLE_LIMIT)
        begin
            zr = -ANGLE_LIMIT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0] <= x0;
            y_reg[0] <= y0;
            z_reg[0] <= z0;
            zero_reg[0] <= (x_in == 0) && (y_in == 0);
            for (int i = 0; i < ITERS; i++)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_tab(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_tab(i);
                end
            end
            angle_reg <= zero_reg[ITERS] ? 16'sd0 : zr[15:0];
        end
    end

    assign angle = angle_reg;
endmodule

FILE: design/rotation_matrix_to_euler_angles_unit.sv
// Converts a 3x3 rotation matrix (nine signed Q1.14 entries) into three Euler
// angles in signed 1/128-degree units plus a gimbal lock flag.
// The input channel takes one request per cycle when in_stall is low; the
// output channel presents results with out_valid, held while out_stall is high.
// From an accepted request to out_valid the pipeline has one product
// stage, 17 integer square root stages, one selection stage, one CORDIC
// preload stage, 16 CORDIC iteration stages, one rounding stage, and the
// output register. Throughput is one request per cycle while in_stall is low.
// The whole pipeline advances together; while the output is held, in_stall
// is high and no stage moves, so nothing is lost or repeated.
// Reset clears all valid bits and sets the threshold to zero. The threshold
// should be written only while the pipeline is empty.
module rotation_matrix_to_euler_angles_unit (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic in_valid,
    output logic in_stall,
    input  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
    output logic out_valid,
    input  logic out_stall,
    output logic signed [15:0] angle_first,
    output logic signed [15:0] angle_second,
    output logic signed [15:0] angle_third,
    output logic gimbal_locked
);
    import rme_pkg::*;

    localparam int SQ = 17;
    localparam int LAT = SQ + 2 + ITERS + 2;

    logic [7:0] thr_reg;
    logic advance;
    logic vld_reg [LAT+1];

    typedef struct packed {
        logic signed [16:0] d;
        logic signed [15:0] r00, r01, r02, r10, r11, r20, r21, r22;
    } ent_t;

    ent_t e_reg [SQ+1];
    logic [RADW-1:0] v_reg [SQ+1];
    logic [RADW-1:0] q_reg [SQ+1];
    logic [RADW-1:0] b_reg [SQ+1];
    logic signed [18:0] ay_reg [3], ax_reg [3];
    logic lk_reg [ITERS+3];
    logic signed [15:0] a1, a2, a3;
    logic signed [RADW:0] rad;
    ent_t e_in;

    assign advance = !(vld_reg[LAT] && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
    end

    always_comb
    begin
        e_in = '{d: -17'(r12), r00: r00, r01: r01, r02: r02, r10: r10, r11: r11,
                 r20: r20, r21: r21, r22: r22};
        rad = (33'sd1 <<< (2 * FRAC_BITS)) - 33'(-r12) * 33'(-r12);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e_reg[0] <= e_in;
            v_reg[0] <= (rad > 0) ? rad[RADW-1:0] : '0;
            q_reg[0] <= '0;
            b_reg[0] <= {2'b01, {(RADW-2){1'b0}}};
            for (int i = 0; i < SQ; i++)
            begin
                e_reg[i+1] <= e_reg[i];
                b_reg[i+1] <= b_reg[i] >> 2;
                if (b_reg[i] != 0 && v_reg[i] >= q_reg[i] + b_reg[i])
                begin
                    v_reg[i+1] <= v_reg[i] - (q_reg[i] + b_reg[i]);
                    q_reg[i+1] <= (q_reg[i] >> 1) + b_reg[i];
                end
                else
                begin
                    v_reg[i+1] <= v_reg[i];
                    q_reg[i+1] <= (b_reg[i] != 0) ? (q_reg[i] >> 1) : q_reg[i];
                end
            end
        end
    end

    logic signed [18:0] c_s, d_s, ae, af, be, saf, sae2, sbe, sae3;
    logic locked;
    ent_t e;

    always_comb
    begin
        e = e_reg[SQ];
        c_s = 19'(signed'({1'b0, q_reg[SQ][CW-1:0]}));
        d_s = 19'(e.d);
        locked = c_s <= 19'(signed'({1'b0, thr_reg}));
        if (e.d > 0)
        begin
            ae = 19'(e.r00) + 19'(e.r21);
            af = 19'(e.r01) + 19'(e.r20);
            be = 19'(e.r01) - 19'(e.r20);
        end
        else
        begin
            ae = 19'(e.r00) - 19'(e.r21);
            af = 19'(e.r01) - 19'(e.r20);
            be = 19'(e.r01) + 19'(e.r20);
        end
        if (((af < 0) ? -af : af) > 19'(signed'({1'b0, thr_reg})) ? af < 0 : ae < 0)
        begin
            saf = -af;
            sae3 = -ae;
        end
        else
        begin
            saf = af;
            sae3 = ae;
        end
        if (((be < 0) ? -be : be) > 19'(signed'({1'b0, thr_reg})) ? be < 0 : ae < 0)
        begin
            sbe = -be;
            sae2 = -ae;
        end
        else
        begin
            sbe = be;
            sae2 = ae;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ay_reg[0] <= d_s;
            ax_reg[0] <= locked ? '0 : c_s;
            ay_reg[1] <= locked ? sbe : 19'(e.r02);
            ax_reg[1] <= locked ? sae2 : 19'(e.r22);
            ay_reg[2] <= locked ? saf : 19'(e.r10);
            ax_reg[2] <= locked ? sae3 : 19'(e.r11);
            lk_reg[0] <= locked;
            for (int i = 0; i < ITERS + 2; i++)
            begin
                lk_reg[i+1] <= lk_reg[i];
            end
        end
    end

    rme_cordic u_c1 (.clk, .advance, .y_in(ay_reg[0]), .x_in(ax_reg[0]), .angle(a1));
    rme_cordic u_c2 (.clk, .advance, .y_in(ay_reg[1]), .x_in(ax_reg[1]), .angle(a2));
    rme_cordic u_c3 (.clk, .advance, .y_in(ay_reg[2]), .x_in(ax_reg[2]), .angle(a3));

    logic signed [15:0] o1_reg, o2_reg, o3_reg;
    logic ol_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            o1_reg <= a1;
            o2_reg <= a2;
            o3_reg <= a3;
            ol_reg <= lk_reg[ITERS+2];
        end
    end

    assign out_valid = vld_reg[LAT];
    assign angle_first = o1_reg;
    assign angle_second = o2_reg;
    assign angle_third = o3_reg;
    assign gimbal_locked = ol_reg;

`ifndef SYNTHESIS
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output hold");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(angle_first) && $stable(gimbal_locked)))
        else $error("held result changed");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (angle_first <= 16'sd23040 && angle_first >= -16'sd23040))
        else $error("angle out of range");
`endif
endmodule

FILE: verif/testbench.sv
module testbench;
    import rme_pkg::*;

    localparam int LATENCY = 39;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_RANDOM = 1250;

    typedef struct {
        logic signed [15:0] r [9];
    } matrix_t;

    typedef struct packed {
        logic signed [15:0] first;
        logic signed [15:0] second;
        logic signed [15:0] third;
        logic               locked;
    } euler_t;

    typedef struct {
        logic signed [15:0] r [9];
        logic               has_known;
        euler_t             known;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [7:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] r00 = '0, r01 = '0, r02 = '0, r10 = '0, r11 = '0, r12 = '0;
    logic signed [15:0] r20 = '0, r21 = '0, r22 = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] angle_first, angle_second, angle_third;
    logic gimbal_locked;

    euler_t expected_angles [$];
    int     mismatch_count = 0;
    int     cycle_count = 0;
    logic [7:0] threshold_model = '0;
    bit     hold_off_request = 1'b0;
    bit     hold_off_done = 1'b0;
    bit     sink_quiet = 1'b0;

    rotation_matrix_to_euler_angles_unit DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
        .r20(r20), .r21(r21), .r22(r22),
        .out_valid(out_valid), .out_stall(out_stall),
        .angle_first(angle_first), .angle_second(angle_second),
        .angle_third(angle_third), .gimbal_locked(gimbal_locked)
    );

    always #2 clk = ~clk;

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint root_floor(longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >>> 1) + bitv;
            end
            else
                res = res >>> 1;
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] cordic_angle(longint y, longint x);
        longint z;
        longint xs;
        longint ys;
        longint r;
        if (x == 0 && y == 0)
            return '0;
        z = 0;
        x = x * (64'sd1 <<< SCALE_SH);
        y = y * (64'sd1 <<< SCALE_SH);
        if (x < 0)
        begin
            z = (y >= 0) ? longint'(DEG180) : -longint'(DEG180);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ITERS; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_tab(i));
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_tab(i));
            end
        end
        r = floor_shift(z + 256, 9);
        if (r > longint'(ANGLE_LIMIT))
            r = longint'(ANGLE_LIMIT);
        if (r < -longint'(ANGLE_LIMIT))
            r = -longint'(ANGLE_LIMIT);
        return r[15:0];
    endfunction

    function automatic euler_t predict_euler(matrix_t m);
        euler_t e;
        longint thr, d, rad, c, sg, ae, af, be, s;
        thr = longint'(threshold_model);
        d = -longint'(m.r[5]);
        rad = (64'sd1 <<< (2 * FRAC_BITS)) - d * d;
        c = (rad > 0) ? root_floor(rad) : 0;
        e.locked = (c <= thr);
        if (!e.locked)
        begin
            e.first = cordic_angle(d, c);
            e.second = cordic_angle(m.r[2], m.r[8]);
            e.third = cordic_angle(m.r[3], m.r[4]);
        end
        else
        begin
            sg = (d > 0) ? 1 : -1;
            ae = longint'(m.r[0]) + sg * longint'(m.r[7]);
            af = longint'(m.r[1]) + sg * longint'(m.r[6]);
            be = longint'(m.r[1]) - sg * longint'(m.r[6]);
            e.first = cordic_angle(d, 0);
            if ((af < 0 ? -af : af) > thr)
                s = (af < 0) ? -1 : 1;
            else
                s = (ae < 0) ? -1 : 1;
            e.third = cordic_angle(s * af, s * ae);
            if ((be < 0 ? -be : be) > thr)
                s = (be < 0) ? -1 : 1;
            else
                s = (ae < 0) ? -1 : 1;
            e.second = cordic_angle(s * be, s * ae);
        end
        return e;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin : sink_proc
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_request && !hold_off_done)
            begin
                out_stall <= 1'b1;
                for (int i = 0; i < 300; i++)
                    @(posedge clk);
                hold_off_done = 1'b1;
                out_stall <= 1'b0;
            end
            else if (sink_quiet)
                out_stall <= 1'b0;
            else
            begin
                hold = $urandom_range(0, 99);
                if (hold < 60)
                    out_stall <= 1'b0;
                else if (hold < 97)
                    out_stall <= 1'b1;
                else
                begin
                    out_stall <= 1'b1;
                    for (int i = 0; i < $urandom_range(10, 60); i++)
                        @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_angles.size() == 0)
            begin
                $display("%0t: unexpected result first=%0d second=%0d third=%0d locked=%0b",
                         $time, angle_first, angle_second, angle_third, gimbal_locked);
                mismatch_count++;
            end
            else
            begin : compare_blk
                euler_t e;
                e = expected_angles.pop_front();
                if (angle_first !== e.first)
                begin
                    $display("%0t: angle_first expected %0d actual %0d",
                             $time, e.first, angle_first);
                    mismatch_count++;
                end
                if (angle_second !== e.second)
                begin
                    $display("%0t: angle_second expected %0d actual %0d",
                             $time, e.second, angle_second);
                    mismatch_count++;
                end
                if (angle_third !== e.third)
                begin
                    $display("%0t: angle_third expected %0d actual %0d",
                             $time, e.third, angle_third);
                    mismatch_count++;
                end
                if (gimbal_locked !== e.locked)
                begin
                    $display("%0t: gimbal_locked expected %0b actual %0b",
                             $time, e.locked, gimbal_locked);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_request(matrix_t m, bit has_known, euler_t known);
        euler_t e;
        in_valid <= 1'b1;
        r00 <= m.r[0]; r01 <= m.r[1]; r02 <= m.r[2];
        r10 <= m.r[3]; r11 <= m.r[4]; r12 <= m.r[5];
        r20 <= m.r[6]; r21 <= m.r[7]; r22 <= m.r[8];
        do
            @(posedge clk);
        while (in_stall);
        e = predict_euler(m);
        if (has_known && e != known)
        begin
            $display("%0t: table row expected %0d %0d %0d %0b, predictor gives %0d %0d %0d %0b",
                     $time, known.first, known.second, known.third, known.locked,
                     e.first, e.second, e.third, e.locked);
            mismatch_count++;
        end
        expected_angles.push_back(has_known ? known : e);
    endtask

    task automatic source_gap(bit allow_gap);
        int g;
        g = $urandom_range(0, 99);
        if (!allow_gap || g < 65)
            return;
        in_valid <= 1'b0;
        if (g < 96)
            repeat ($urandom_range(1, 3)) @(posedge clk);
        else
            repeat ($urandom_range(20, 80)) @(posedge clk);
    endtask

    task automatic drain_and_write(logic [7:0] value);
        in_valid <= 1'b0;
        while (expected_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        threshold_model = value;
    endtask

    function automatic logic signed [15:0] random_entry();
        int k;
        k = $urandom_range(0, 99);
        if (k < 80)
            return 16'($urandom_range(0, 32768) - 16384);
        else if (k < 90)
            return 16'($urandom_range(0, 600) - 300);
        return 16'($urandom());
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t m;
        int kind;
        real a, b, g, ca, sa, cb, sb, cg, sg;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 9; i++)
            m.r[i] = random_entry();
        if (kind < 55)
        begin
            a = ($urandom_range(0, 65535) / 65535.0 - 0.5) * 6.2831853;
            b = ($urandom_range(0, 65535) / 65535.0 - 0.5) * 3.1415926;
            g = ($urandom_range(0, 65535) / 65535.0 - 0.5) * 6.2831853;
            ca = $cos(a); sa = $sin(a); cb = $cos(b); sb = $sin(b);
            cg = $cos(g); sg = $sin(g);
            m.r[0] = 16'($rtoi(16384.0 * (ca * cg + sa * sb * sg)));
            m.r[1] = 16'($rtoi(16384.0 * (sa * sb * cg - ca * sg)));
            m.r[2] = 16'($rtoi(16384.0 * sa * cb));
            m.r[3] = 16'($rtoi(16384.0 * cb * sg));
            m.r[4] = 16'($rtoi(16384.0 * cb * cg));
            m.r[5] = 16'($rtoi(-16384.0 * sb));
            m.r[6] = 16'($rtoi(16384.0 * (ca * sb * sg - sa * cg)));
            m.r[7] = 16'($rtoi(16384.0 * (sa * sg + ca * sb * cg)));
            m.r[8] = 16'($rtoi(16384.0 * ca * cb));
        end
        else if (kind < 80)
            m.r[5] = 16'(($urandom_range(0, 1) ? 16384 : -16384) + $urandom_range(0, 8) - 4);
        else if (kind < 88)
            m.r[5] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        return m;
    endfunction

    directed_row_t directed_table [$];

    task automatic add_row(logic signed [15:0] a0, a1, a2, a3, a4, a5, a6, a7, a8,
                           bit has_known, logic signed [15:0] k1, k2, k3, logic kl);
        directed_row_t row;
        row.r = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
        row.has_known = has_known;
        row.known = '{k1, k2, k3, kl};
        directed_table.push_back(row);
    endtask

    initial
    begin : stimulus_proc
        matrix_t m;
        euler_t none;
        logic [7:0] settings [4];
        none = '{'0, '0, '0, 1'b0};
        settings = '{8'd255, 8'd17, 8'd0, 8'd128};

        // Identity, and all-zero matrix where c = 1 and both pairs are 0/0.
        add_row(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        // Vectors on the negative x axis give +180 degrees.
        add_row(0, 0, 0, 0, -16384, 0, 0, 0, -16384, 1, 0, 23040, 23040, 0);
        // Gimbal lock with d = +1 and d = -1.
        add_row(16384, 0, 0, 0, 0, -16384, 0, 16384, 0, 0, 0, 0, 0, 0);
        add_row(0, 16384, 0, 0, 0, 16384, 16384, 0, 0, 0, 0, 0, 0, 0);
        // Gimbal lock with both pairs 0/0.
        add_row(0, 0, 0, 0, 0, 16384, 0, 0, 0, 1, -11520, 0, 0, 1);
        // Small pair over zero.
        add_row(0, 3, 0, 0, 0, -16384, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, -2, 0, 0, 0, 16384, 5, 0, 0, 0, 0, 0, 0, 0);
        // Extremes and out-of-range patterns.
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                0, 0, 0, 0, 0);
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                0, 0, 0, 0, 0);
        add_row(-16384, 16384, -16384, 16384, -16384, 16384, -16384, 16384, -16384,
                0, 0, 0, 0, 0);
        add_row(16384, -16384, 16384, -16384, 16384, -16384, 16384, -16384, 16384,
                0, 0, 0, 0, 0);
        add_row(-1, -1, -1, -1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 1, 16383, 0, 1, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 1, 0, 0, -16383, 0, 0, -1, 0, 0, 0, 0, 0);
        add_row(21845, -10923, 8192, -8192, 10923, -21845, 4096, -4096, 1234,
                0, 0, 0, 0, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[i])
        begin
            m.r = directed_table[i].r;
            send_request(m, directed_table[i].has_known, directed_table[i].known);
        end

        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase > 0)
                drain_and_write(settings[phase - 1]);
            if (phase == 1)
                hold_off_request = 1'b1;
            for (int n = 0; n < NUM_RANDOM / 5; n++)
            begin
                send_request(random_matrix(), 1'b0, none);
                source_gap(!(phase == 1 && !hold_off_done));
            end
            if (phase == 2)
            begin
                in_valid <= 1'b0;
                while (expected_angles.size() != 0)
                    @(posedge clk);
            end
        end

        in_valid <= 1'b0;
        sink_quiet = 1'b1;
        while (expected_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
